// ===== rtl/core/drive_slew_follower_with_homing_defines.svh =====
// assertion macros shared by the slew follower rtl
// no dependencies; every macro samples on clk and is disabled while arst_n is low
`ifndef DRIVE_SLEW_FOLLOWER_WITH_HOMING_DEFINES_SVH
`define DRIVE_SLEW_FOLLOWER_WITH_HOMING_DEFINES_SVH

// same-cycle implication
`define DSF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DSF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/dsf_pkg.sv =====
// types, register codes and the clamp helper for the slew follower
// no dependencies; used by dsf_rudder and drive_slew_follower_with_homing
package dsf_pkg;

	localparam int unsigned ANGLE_W = 16;
	localparam int unsigned LIMIT_W = 15;
	localparam int unsigned DELTA_W = ANGLE_W + 1;

	localparam logic [LIMIT_W-1:0] CFG_RESET_VALUE = 15'd91;

	typedef logic [LIMIT_W-1:0] limit_t;

	typedef enum logic [1:0] {
		CFG_SAIL_STEP_LIMIT   = 2'd0,
		CFG_RUDDER_STEP_LIMIT = 2'd1,
		CFG_HOMING_STEP       = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic signed [15:0] sail_target;
		logic               sail_target_ok;
		logic signed [15:0] left_target;
		logic               left_target_ok;
		logic signed [15:0] right_target;
		logic               right_target_ok;
	} dsf_in_t;

	typedef struct packed {
		logic signed [15:0] sail_position;
		logic signed [15:0] left_position;
		logic signed [15:0] right_position;
		logic               left_is_homed;
		logic               right_is_homed;
	} dsf_out_t;

	// next state of one rudder, handed to the top level
	typedef struct packed {
		logic signed [15:0] angle;
		logic               homed;
	} dsf_rudder_t;

	// symmetric clamp of a 17-bit delta to +-lim
	function automatic logic signed [DELTA_W-1:0] dsf_clamp(
		input logic signed [DELTA_W-1:0] d,
		input logic [LIMIT_W-1:0]        lim
	);
		logic signed [DELTA_W-1:0] hi;
		logic signed [DELTA_W-1:0] lo;
		logic signed [DELTA_W-1:0] r;
		hi = $signed({2'b00, lim});
		lo = -hi;
		if (d > hi) begin
			r = hi;
		end else if (d < lo) begin
			r = lo;
		end else begin
			r = d;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/dsf_rudder.sv =====
// one rudder drive: homing sweep, then rate-limited follow of the target
// depends on dsf_pkg and drive_slew_follower_with_homing_defines.svh
`include "drive_slew_follower_with_homing_defines.svh"

module dsf_rudder #(
	parameter logic signed [15:0] HOME_ANGLE = 16'sd16384,
	parameter bit                 HOME_UP    = 1'b1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic signed [15:0]   target,
	input  dsf_pkg::limit_t      step_limit,
	input  dsf_pkg::limit_t      homing_step,
	output dsf_pkg::dsf_rudder_t next_state
);
	import dsf_pkg::*;

	logic signed [15:0]        angle_q;
	logic                      homed_q;
	logic signed [15:0]        home_move;
	logic                      home_done;
	logic signed [DELTA_W-1:0] delta;
	logic signed [DELTA_W-1:0] delta_clamped;
	logic signed [15:0]        follow_move;

	always_comb begin
		if (HOME_UP) begin
			home_move = angle_q + $signed({1'b0, homing_step});
			home_done = home_move > HOME_ANGLE;
		end else begin
			home_move = angle_q - $signed({1'b0, homing_step});
			home_done = home_move < HOME_ANGLE;
		end
		// unwrapped difference, one bit wider than the angles
		delta         = {target[15], target} - {angle_q[15], angle_q};
		delta_clamped = dsf_clamp(delta, step_limit);
		follow_move   = angle_q + delta_clamped[15:0];

		if (homed_q) begin
			next_state.angle = follow_move;
			next_state.homed = 1'b1;
		end else begin
			next_state.angle = home_move;
			next_state.homed = home_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			homed_q <= 1'b0;
		end else if (advance) begin
			angle_q <= next_state.angle;
			homed_q <= next_state.homed;
		end
	end

	`DSF_ASSERT_NEXT(a_homed_sticky, homed_q, homed_q, "homed flag dropped")
	`DSF_ASSERT_NEXT(a_angle_holds, !advance, $stable(angle_q), "rudder moved without a tick")
	`DSF_ASSERT_NOW(a_home_on_tick, $rose(homed_q), $past(advance), "homed without a tick")

endmodule

// ===== rtl/core/drive_slew_follower_with_homing.sv =====
// top level of the sail and rudder slew follower with rudder homing
// depends on dsf_pkg, dsf_rudder and drive_slew_follower_with_homing_defines.svh
`include "drive_slew_follower_with_homing_defines.svh"

// Slew follower for three drives. Each request is one control tick with a
// target for the sail and for each rudder; a target whose ok bit is low counts
// as zero. Angles are 16-bit binary angles (65536 to a full turn). The sail
// steps toward its target the short way round, by at most sail_step_limit.
// Each rudder first homes at homing_step per tick (left upward past
// LEFT_HOME_ANGLE, right downward below RIGHT_HOME_ANGLE), then follows its
// target along the plain difference by at most rudder_step_limit. One request
// is taken every cycle while item_ready is high, and its result is registered.
// Every request reads and writes the angle registers. A result register with a
// one-entry skid behind it lets the block take one more request while a result
// is stalled; item_ready drops only when both hold a result. Configuration
// writes take effect at once and are meant to happen only while the block is
// idle.
module drive_slew_follower_with_homing #(
	parameter logic signed [15:0] LEFT_HOME_ANGLE  = 16'sd16384,
	parameter logic signed [15:0] RIGHT_HOME_ANGLE = -16'sd18204
) (
	input  logic              clk,
	input  logic              arst_n,
	// request channel
	input  logic              item_valid,
	output logic              item_ready,
	input  dsf_pkg::dsf_in_t  item,
	// result channel
	output logic              result_valid,
	input  logic              result_ready,
	output dsf_pkg::dsf_out_t result,
	// configuration writes
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [14:0]       cfg_wdata
);
	import dsf_pkg::*;

	// configuration registers
	limit_t sail_limit_q;
	limit_t rudder_limit_q;
	limit_t homing_step_q;

	// sail state
	logic signed [15:0]        sail_q;
	logic signed [15:0]        sail_target;
	logic signed [15:0]        sail_delta;
	logic signed [DELTA_W-1:0] sail_delta_clamped;
	logic signed [15:0]        sail_next;

	// rudder targets after the ok-bit check
	logic signed [15:0] left_target;
	logic signed [15:0] right_target;

	dsf_rudder_t left_next;
	dsf_rudder_t right_next;
	dsf_out_t    step_result;

	// result register and skid entry
	dsf_out_t result_q;
	logic     result_valid_q;
	dsf_out_t skid_q;
	logic     skid_valid_q;

	logic accept;
	logic pop;

	assign item_ready   = !skid_valid_q;
	assign accept       = item_valid && item_ready;
	assign pop          = result_valid_q && result_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// config write port, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sail_limit_q   <= CFG_RESET_VALUE;
			rudder_limit_q <= CFG_RESET_VALUE;
			homing_step_q  <= CFG_RESET_VALUE;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_SAIL_STEP_LIMIT:   sail_limit_q   <= cfg_wdata;
				CFG_RUDDER_STEP_LIMIT: rudder_limit_q <= cfg_wdata;
				CFG_HOMING_STEP:       homing_step_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// invalid targets stand for zero
	assign sail_target  = item.sail_target_ok  ? item.sail_target  : '0;
	assign left_target  = item.left_target_ok  ? item.left_target  : '0;
	assign right_target = item.right_target_ok ? item.right_target : '0;

	// sail: wrapped difference gives the short way round, then clamp
	always_comb begin
		sail_delta         = sail_target - sail_q;
		sail_delta_clamped = dsf_clamp({sail_delta[15], sail_delta}, sail_limit_q);
		sail_next          = sail_q + sail_delta_clamped[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sail_q <= '0;
		end else if (accept) begin
			sail_q <= sail_next;
		end
	end

	// left rudder homes upward, right rudder downward
	dsf_rudder #(
		.HOME_ANGLE (LEFT_HOME_ANGLE),
		.HOME_UP    (1'b1)
	) u_left (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (accept),
		.target      (left_target),
		.step_limit  (rudder_limit_q),
		.homing_step (homing_step_q),
		.next_state  (left_next)
	);

	dsf_rudder #(
		.HOME_ANGLE (RIGHT_HOME_ANGLE),
		.HOME_UP    (1'b0)
	) u_right (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (accept),
		.target      (right_target),
		.step_limit  (rudder_limit_q),
		.homing_step (homing_step_q),
		.next_state  (right_next)
	);

	always_comb begin
		step_result.sail_position  = sail_next;
		step_result.left_position  = left_next.angle;
		step_result.right_position = right_next.angle;
		step_result.left_is_homed  = left_next.homed;
		step_result.right_is_homed = right_next.homed;
	end

	// result register with skid: the skid fills only when the result
	// register is stalled, and drains into it on the next pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			skid_valid_q   <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (!result_valid_q || pop) begin
				result_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			result_valid_q <= 1'b0;
		end
	end

	// payload side, no reset needed
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				result_q <= skid_q;
			end
		end else if (accept) begin
			if (!result_valid_q || pop) begin
				result_q <= step_result;
			end else begin
				skid_q <= step_result;
			end
		end
	end

	`DSF_ASSERT_NOW(a_skid_behind_result, skid_valid_q, result_valid_q, "skid holds data ahead of result")
	`DSF_ASSERT_NEXT(a_accept_shows, accept && !result_valid_q, result_valid_q, "accepted request gave no result")
	`DSF_ASSERT_NEXT(a_skid_drains, skid_valid_q && pop, !skid_valid_q && result_valid_q, "skid did not drain")
	`DSF_ASSERT_NEXT(a_sail_holds, !accept, $stable(sail_q), "sail moved without a request")

endmodule

// ===== sim/tb_top.sv =====
// testbench for drive_slew_follower_with_homing: directed ticks, then random ticks
// depends on dsf_pkg and the rtl top; checks every result against its own drive model or a pinned expectation
`timescale 1ns / 1ps

module tb_top;
	import dsf_pkg::*;

	localparam int CLK_HALF      = 2;
	localparam int RESET_CYCLES  = 6;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 8;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_TICKS   = 200;
	localparam int QUIET_PHASE   = 4;
	localparam int IDLE_PERCENT  = 9;

	// rudder homing thresholds, signed binary angles
	localparam int LEFT_HOME  = 16384;
	localparam int RIGHT_HOME = -18204;

	typedef enum logic {
		PLAN_TICK,
		PLAN_WRITE
	} plan_kind_t;

	// one line of the directed table: a tick or a register write
	typedef struct {
		plan_kind_t kind;
		dsf_in_t    tick;
		bit         typed;
		dsf_out_t   want;
		cfg_index_t reg_idx;
		limit_t     reg_val;
	} plan_row_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        item_valid   = 1'b0;
	logic        item_ready;
	dsf_in_t     item         = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	dsf_out_t    result;
	logic        cfg_we       = 1'b0;
	logic [1:0]  cfg_index    = '0;
	logic [14:0] cfg_wdata    = '0;

	// model of the drives: angles, homing flags and register copies
	logic signed [15:0] sail_pos;
	logic signed [15:0] left_pos;
	logic signed [15:0] right_pos;
	logic               left_homed;
	logic               right_homed;
	limit_t             sail_lim;
	limit_t             rudder_lim;
	limit_t             home_step;

	dsf_out_t  expected_positions[$];
	plan_row_t directed_plan[$];
	int        mismatches  = 0;
	int        cycle_count = 0;
	bit        no_gaps     = 1'b0;

	drive_slew_follower_with_homing u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always #CLK_HALF clk = ~clk;

	// symmetric clamp of a step to +-lim
	function automatic int limit_move(input int d, input int lim);
		if (d > lim) begin
			return lim;
		end
		if (d < -lim) begin
			return -lim;
		end
		return d;
	endfunction

	// one control tick of the model; returns the angles after the tick
	function automatic dsf_out_t advance_drives(input dsf_in_t t);
		logic signed [15:0] sail_goal;
		logic signed [15:0] left_goal;
		logic signed [15:0] right_goal;
		logic signed [15:0] sail_gap;
		dsf_out_t           r;
		// a target with its ok bit low counts as zero
		sail_goal  = t.sail_target_ok  ? t.sail_target  : 16'sd0;
		left_goal  = t.left_target_ok  ? t.left_target  : 16'sd0;
		right_goal = t.right_target_ok ? t.right_target : 16'sd0;

		// sail: difference wrapped to a half turn, so it goes the short way round
		sail_gap = sail_goal - sail_pos;
		sail_pos = 16'(int'(sail_pos) + limit_move(int'(sail_gap), int'(sail_lim)));

		// left rudder homes upward, then follows along the plain difference
		if (!left_homed) begin
			left_pos = 16'(int'(left_pos) + int'(home_step));
			if (int'(left_pos) > LEFT_HOME) begin
				left_homed = 1'b1;
			end
		end else begin
			left_pos = 16'(int'(left_pos)
				+ limit_move(int'(left_goal) - int'(left_pos), int'(rudder_lim)));
		end

		// right rudder homes downward
		if (!right_homed) begin
			right_pos = 16'(int'(right_pos) - int'(home_step));
			if (int'(right_pos) < RIGHT_HOME) begin
				right_homed = 1'b1;
			end
		end else begin
			right_pos = 16'(int'(right_pos)
				+ limit_move(int'(right_goal) - int'(right_pos), int'(rudder_lim)));
		end

		r.sail_position  = sail_pos;
		r.left_position  = left_pos;
		r.right_position = right_pos;
		r.left_is_homed  = left_homed;
		r.right_is_homed = right_homed;
		return r;
	endfunction

	function automatic limit_t random_limit();
		case ($urandom_range(5))
			0: return '0;
			1: return 15'h7FFF;
			2: return 15'd1;
			3: return limit_t'($urandom_range(32767));
			default: return limit_t'($urandom_range(400, 1));
		endcase
	endfunction

	// table building
	task automatic plan_tick(input int st, input bit sok, input int lt, input bit lok,
			input int rt, input bit rok);
		plan_row_t row;
		row.kind                 = PLAN_TICK;
		row.tick.sail_target     = 16'(st);
		row.tick.sail_target_ok  = sok;
		row.tick.left_target     = 16'(lt);
		row.tick.left_target_ok  = lok;
		row.tick.right_target    = 16'(rt);
		row.tick.right_target_ok = rok;
		row.typed                = 1'b0;
		row.want                 = '0;
		row.reg_idx              = CFG_SAIL_STEP_LIMIT;
		row.reg_val              = '0;
		directed_plan.push_back(row);
	endtask

	// pins the expected result of the last tick in the table
	task automatic expect_last(input int sp, input int lp, input int rp, input bit lh,
			input bit rh);
		plan_row_t row;
		row                     = directed_plan.pop_back();
		row.typed               = 1'b1;
		row.want.sail_position  = 16'(sp);
		row.want.left_position  = 16'(lp);
		row.want.right_position = 16'(rp);
		row.want.left_is_homed  = lh;
		row.want.right_is_homed = rh;
		directed_plan.push_back(row);
	endtask

	task automatic plan_write(input cfg_index_t idx, input limit_t val);
		plan_row_t row;
		row.kind    = PLAN_WRITE;
		row.tick    = '0;
		row.typed   = 1'b0;
		row.want    = '0;
		row.reg_idx = idx;
		row.reg_val = val;
		directed_plan.push_back(row);
	endtask

	// drives one request and waits for it to be taken; valid is left high so a
	// following request can go out back to back
	task automatic send_tick(input dsf_in_t t, input bit typed, input dsf_out_t want);
		dsf_out_t predicted;
		item_valid <= 1'b1;
		item       <= t;
		do @(posedge clk); while (!item_ready);
		predicted = advance_drives(t);
		expected_positions.push_back(typed ? want : predicted);
	endtask

	// register write, only once every pending result has come back
	task automatic write_reg(input cfg_index_t idx, input limit_t val);
		item_valid <= 1'b0;
		while (expected_positions.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SAIL_STEP_LIMIT:   sail_lim   = val;
			CFG_RUDDER_STEP_LIMIT: rudder_lim = val;
			CFG_HOMING_STEP:       home_step  = val;
			default: ;
		endcase
	endtask

	// result side: random stalls, none during the quiet phase
	always @(posedge clk) begin
		result_ready <= no_gaps || ($urandom_range(99) >= IDLE_PERCENT);
	end

	// result checker: each taken result against the oldest expectation
	always @(posedge clk) begin
		dsf_out_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_positions.size() == 0) begin
				$error("result with no request pending: sail %0d left %0d right %0d",
					result.sail_position, result.left_position, result.right_position);
				mismatches++;
			end else begin
				want = expected_positions.pop_front();
				if (result.sail_position !== want.sail_position) begin
					$error("sail_position: expected %0d, got %0d",
						want.sail_position, result.sail_position);
					mismatches++;
				end
				if (result.left_position !== want.left_position) begin
					$error("left_position: expected %0d, got %0d",
						want.left_position, result.left_position);
					mismatches++;
				end
				if (result.right_position !== want.right_position) begin
					$error("right_position: expected %0d, got %0d",
						want.right_position, result.right_position);
					mismatches++;
				end
				if (result.left_is_homed !== want.left_is_homed) begin
					$error("left_is_homed: expected %0b, got %0b",
						want.left_is_homed, result.left_is_homed);
					mismatches++;
				end
				if (result.right_is_homed !== want.right_is_homed) begin
					$error("right_is_homed: expected %0b, got %0b",
						want.right_is_homed, result.right_is_homed);
					mismatches++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		dsf_in_t tick;
		int      offs;
		// model starts from its reset state
		sail_pos    = '0;
		left_pos    = '0;
		right_pos   = '0;
		left_homed  = 1'b0;
		right_homed = 1'b0;
		sail_lim    = CFG_RESET_VALUE;
		rudder_lim  = CFG_RESET_VALUE;
		home_step   = CFG_RESET_VALUE;

		// reset defaults: first steps are plain multiples of 91
		plan_tick(100, 1, 500, 1, -500, 1);
		expect_last(91, 91, -91, 0, 0);
		// sail ok bit low, so the target is zero
		plan_tick(12345, 0, -1, 0, 1, 0);
		expect_last(0, 182, -182, 0, 0);
		// exactly a half turn away clamps to the negative limit
		plan_tick(-32768, 1, 0, 1, 0, 1);
		expect_last(-91, 273, -273, 0, 0);
		// zero homing step: rudders stay where they are
		plan_write(CFG_HOMING_STEP, 15'd0);
		plan_tick(32767, 1, -1, 1, 1, 1);
		plan_tick(-1, 0, 32767, 1, -32768, 1);
		// widest steps: sail wraps, homing carries round the wrap without homing
		plan_write(CFG_SAIL_STEP_LIMIT, 15'h7FFF);
		plan_write(CFG_RUDDER_STEP_LIMIT, 15'h7FFF);
		plan_write(CFG_HOMING_STEP, 15'h7FFF);
		plan_tick(32767, 1, 0, 0, 0, 0);
		plan_tick(-32768, 1, 1000, 1, -1000, 1);
		// one big homing step takes both rudders past their thresholds
		plan_write(CFG_HOMING_STEP, 15'd20000);
		plan_tick(0, 1, -32768, 1, 32767, 1);
		// homed: follow along the unwrapped difference, extremes of both ends
		plan_tick(21845, 1, 32767, 1, -32768, 1);
		plan_tick(-21846, 1, -32768, 1, 32767, 1);
		plan_tick(32767, 0, 12345, 0, -12345, 0);
		// zero step limits: nothing moves
		plan_write(CFG_SAIL_STEP_LIMIT, 15'd0);
		plan_write(CFG_RUDDER_STEP_LIMIT, 15'd0);
		plan_tick(16384, 1, 32767, 1, -32768, 1);
		plan_tick(-16384, 1, -32768, 1, 32767, 1);
		// unit steps
		plan_write(CFG_SAIL_STEP_LIMIT, 15'd1);
		plan_write(CFG_RUDDER_STEP_LIMIT, 15'd1);
		plan_write(CFG_HOMING_STEP, CFG_RESET_VALUE);
		plan_tick(-32768, 1, 100, 1, -100, 1);
		plan_tick(32767, 1, -100, 1, 100, 1);
		plan_write(CFG_SAIL_STEP_LIMIT, CFG_RESET_VALUE);
		plan_write(CFG_RUDDER_STEP_LIMIT, CFG_RESET_VALUE);
		plan_tick(50, 1, 30, 1, -30, 1);
		plan_tick(-21846, 1, 21845, 1, -21846, 1);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == PLAN_WRITE) begin
				write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
			end else begin
				send_tick(directed_plan[i].tick, directed_plan[i].typed,
					directed_plan[i].want);
			end
		end

		// random phases, each with its own register setting
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			write_reg(CFG_SAIL_STEP_LIMIT, random_limit());
			write_reg(CFG_RUDDER_STEP_LIMIT, random_limit());
			write_reg(CFG_HOMING_STEP, random_limit());
			no_gaps = (ph == QUIET_PHASE);
			for (int n = 0; n < PHASE_TICKS; n++) begin
				// a quarter of the targets sit near the current angle so that
				// unclamped steps and arrivals are exercised too
				tick = dsf_in_t'({$urandom, $urandom});
				if ($urandom_range(3) == 0) begin
					offs = int'($urandom_range(300)) - 150;
					tick.sail_target = 16'(int'(sail_pos) + offs);
					offs = int'($urandom_range(300)) - 150;
					tick.left_target = 16'(int'(left_pos) + offs);
					offs = int'($urandom_range(300)) - 150;
					tick.right_target = 16'(int'(right_pos) + offs);
				end
				tick.sail_target_ok  = ($urandom_range(9) != 0);
				tick.left_target_ok  = ($urandom_range(9) != 0);
				tick.right_target_ok = ($urandom_range(9) != 0);
				// sender idles now and then, one cycle at a time
				if (!no_gaps && $urandom_range(99) < IDLE_PERCENT) begin
					item_valid <= 1'b0;
					@(posedge clk);
				end
				send_tick(tick, 1'b0, '0);
			end
			no_gaps = 1'b0;
		end

		item_valid <= 1'b0;
		while (expected_positions.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_positions.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/dsf_pkg.sv
rtl/core/dsf_rudder.sv
rtl/core/drive_slew_follower_with_homing.sv
sim/tb_top.sv
